### hw/rtl/oat_pkg.sv
package oat_pkg;

  localparam int unsigned EntriesDefault     = 256;
  localparam int unsigned SubcarriersDefault = 64;

  localparam int unsigned LoadW  = 4;
  localparam int unsigned PowerW = 32;
  localparam int unsigned WordW  = LoadW + PowerW;
  localparam int unsigned SumW   = 10;
  localparam int unsigned SymW   = 10;
  localparam int unsigned CountW = 20;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 10;

  localparam logic [LoadW-1:0]  LoadReset  = 4'd1;
  localparam logic [PowerW-1:0] PowerReset = 32'h3F80_0000;

  localparam logic FuncWrite = 1'b0;
  localparam logic FuncRead  = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgCoding  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgSymbols = 1'd1;

  typedef struct packed {
    logic        func;
    logic [7:0]  entry_id;
    logic [5:0]  subcarrier;
    logic [3:0]  bitloading;
    logic [31:0] power_bits;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  sub_index;
    logic [3:0]  load_out;
    logic [31:0] power_out;
    logic [19:0] bit_count;
    logic        last;
  } out_item_t;

  // Bits carried by one subcarrier; in coded mode the value is a modulation mode.
  function automatic logic [LoadW-1:0] load_weight(input logic [LoadW-1:0] v,
                                                   input logic coded);
    logic [LoadW-1:0] w;
    w = v;
    if (coded) begin
      unique case (v)
        4'd1:    w = 4'd1;
        4'd2:    w = 4'd2;
        4'd3:    w = 4'd3;
        4'd4:    w = 4'd4;
        4'd5:    w = 4'd6;
        4'd6:    w = 4'd8;
        4'd7:    w = 4'd9;
        4'd8:    w = 4'd10;
        4'd9:    w = 4'd12;
        default: w = 4'd0;
      endcase
    end
    return w;
  endfunction

endpackage

### hw/rtl/oat_mem.sv
module oat_mem #(
  parameter int unsigned ADDR_W = 14,
  parameter int unsigned DATA_W = oat_pkg::WordW
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int unsigned Depth = 2 ** ADDR_W;

  logic [DATA_W-1:0] mem [Depth];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/oat_ctrl.sv
module oat_ctrl #(
  parameter int unsigned ENTRIES     = oat_pkg::EntriesDefault,
  parameter int unsigned SUBCARRIERS = oat_pkg::SubcarriersDefault,
  parameter int unsigned ID_W        = $clog2(ENTRIES),
  parameter int unsigned SC_W        = (SUBCARRIERS > 1) ? $clog2(SUBCARRIERS) : 1,
  parameter int unsigned ADDR_W      = ID_W + SC_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  oat_pkg::in_item_t             in_data,
  output logic                          busy,
  input  logic                          cfg_valid,
  input  logic [oat_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [oat_pkg::CfgDataW-1:0]  cfg_data,
  output logic                          out_valid,
  output oat_pkg::out_item_t            out_data,
  output logic                          mem_we,
  output logic [ADDR_W-1:0]             mem_waddr,
  output logic [oat_pkg::WordW-1:0]     mem_wdata,
  output logic                          mem_re,
  output logic [ADDR_W-1:0]             mem_raddr,
  input  logic [oat_pkg::WordW-1:0]     mem_rdata
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DRAIN
  } state_t;

  localparam logic [SC_W-1:0] LastPos = SC_W'(SUBCARRIERS - 1);

  state_t                        state_r;
  logic [ADDR_W-1:0]             clr_addr_r;
  logic [ID_W-1:0]               id_r;
  logic [SC_W-1:0]               pos_r;
  logic                          p1_valid_r;
  logic [SC_W-1:0]               p1_pos_r;
  logic                          p1_last_r;
  logic [oat_pkg::SumW-1:0]      sum_r;
  logic [oat_pkg::SumW-1:0]      sum_nxt;
  logic                          coding_r;
  logic [oat_pkg::SymW-1:0]      symbols_r;
  logic                          out_valid_r;
  oat_pkg::out_item_t            out_data_r;

  logic                          accept;
  logic                          id_ok;
  logic                          sc_ok;
  logic [oat_pkg::LoadW-1:0]     rd_load;
  logic [oat_pkg::PowerW-1:0]    rd_power;
  logic [oat_pkg::CountW-1:0]    product;
  logic [oat_pkg::CountW-1:0]    count;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign id_ok  = ({1'b0, in_data.entry_id} < 9'(ENTRIES));
  assign sc_ok  = ({1'b0, in_data.subcarrier} < 7'(SUBCARRIERS));

  // The clearing sweep and item writes share the single write port.
  always_comb begin
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = {oat_pkg::LoadReset, oat_pkg::PowerReset};
    end else begin
      mem_we    = accept && (in_data.func == oat_pkg::FuncWrite) && id_ok && sc_ok;
      mem_waddr = {in_data.entry_id[ID_W-1:0], in_data.subcarrier[SC_W-1:0]};
      mem_wdata = {in_data.bitloading, in_data.power_bits};
    end
  end

  assign mem_re    = (state_r == ST_READ);
  assign mem_raddr = {id_r, pos_r};

  assign rd_load  = mem_rdata[oat_pkg::WordW-1 -: oat_pkg::LoadW];
  assign rd_power = mem_rdata[oat_pkg::PowerW-1:0];

  // Shared accumulate path: one add per subcarrier, the multiply only matters
  // on the final beat of a read.
  assign sum_nxt = sum_r + oat_pkg::SumW'(oat_pkg::load_weight(rd_load, coding_r));
  assign product = oat_pkg::CountW'(sum_nxt) * oat_pkg::CountW'(symbols_r);
  assign count   = coding_r ? (product >> 1) : product;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      pos_r       <= '0;
      p1_valid_r  <= 1'b0;
      sum_r       <= '0;
      coding_r    <= 1'b0;
      symbols_r   <= oat_pkg::SymW'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          oat_pkg::CfgCoding:  coding_r  <= cfg_data[0];
          oat_pkg::CfgSymbols: symbols_r <= cfg_data[oat_pkg::SymW-1:0];
          default: ;
        endcase
      end

      p1_valid_r <= (state_r == ST_READ);
      p1_pos_r   <= pos_r;
      p1_last_r  <= (pos_r == LastPos);

      out_valid_r <= p1_valid_r;
      if (p1_valid_r) begin
        sum_r                <= sum_nxt;
        out_data_r.sub_index <= 6'(p1_pos_r);
        out_data_r.load_out  <= rd_load;
        out_data_r.power_out <= rd_power;
        out_data_r.bit_count <= p1_last_r ? count : '0;
        out_data_r.last      <= p1_last_r;
      end

      unique case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == '1) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && (in_data.func == oat_pkg::FuncRead) && id_ok) begin
            id_r    <= in_data.entry_id[ID_W-1:0];
            pos_r   <= '0;
            sum_r   <= '0;
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          if (pos_r == LastPos) begin
            pos_r   <= '0;
            state_r <= ST_DRAIN;
          end else begin
            pos_r <= pos_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (p1_valid_r && p1_last_r) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hw/rtl/ofdm_allocation_table_core.sv
// Allocation table: ENTRIES entries of SUBCARRIERS subcarriers, each a 4-bit
// loading and a raw 32-bit power word.
// Input channel: an item is taken when start is high and busy is low. A write
// item (func 0) stores one subcarrier in the accept cycle and keeps busy low,
// so writes can follow back to back. A read item (func 1) raises busy and
// streams one beat per subcarrier on out_valid/out_data, one beat per cycle.
// Each beat is read into the memory output register and then registered onto
// the outputs. Busy drops as the last beat is shown, so the next item is taken
// only after the whole read; the beat rate is set by the single read port of
// the table memory and the one accumulator adder that walks the subcarriers.
// The last beat carries the frame bit count. Write items with an id or
// subcarrier outside the table, and reads with an id outside it, are dropped.
// The receiver has no back pressure: each beat is shown for one cycle only.
// Configuration writes on cfg_valid/cfg_index/cfg_data are always taken
// (cfg_ready is tied high) and belong in idle periods.
// After reset the block sweeps all 2**(clog2(ENTRIES) + clog2(SUBCARRIERS))
// words of the table (16384 by default) to their reset contents, one word a
// cycle, with busy high; configuration writes are taken during the sweep.
module ofdm_allocation_table_core #(
  parameter int unsigned ENTRIES     = oat_pkg::EntriesDefault,
  parameter int unsigned SUBCARRIERS = oat_pkg::SubcarriersDefault
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  oat_pkg::in_item_t            in_data,
  output logic                         out_valid,
  output oat_pkg::out_item_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [oat_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [oat_pkg::CfgDataW-1:0] cfg_data
);

  localparam int unsigned IdW   = $clog2(ENTRIES);
  localparam int unsigned ScW   = (SUBCARRIERS > 1) ? $clog2(SUBCARRIERS) : 1;
  localparam int unsigned AddrW = IdW + ScW;

  logic                      mem_we;
  logic [AddrW-1:0]          mem_waddr;
  logic [oat_pkg::WordW-1:0] mem_wdata;
  logic                      mem_re;
  logic [AddrW-1:0]          mem_raddr;
  logic [oat_pkg::WordW-1:0] mem_rdata;

  assign cfg_ready = 1'b1;

  oat_ctrl #(
    .ENTRIES     (ENTRIES),
    .SUBCARRIERS (SUBCARRIERS),
    .ID_W        (IdW),
    .SC_W        (ScW),
    .ADDR_W      (AddrW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  oat_mem #(
    .ADDR_W (AddrW),
    .DATA_W (oat_pkg::WordW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned Entries      = oat_pkg::EntriesDefault;
  localparam int unsigned Subcarriers  = oat_pkg::SubcarriersDefault;
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned PhaseItems   = 86;
  localparam int unsigned PhaseCount   = 5;
  localparam longint unsigned CycleLimit = 400000;

  // Ids that most random traffic lands on, so reads see earlier writes.
  localparam logic [5:0][7:0] HotIds = {8'd255, 8'd254, 8'd128, 8'd2, 8'd1, 8'd0};
  // Coding flag per random phase, bit p for phase p.
  localparam logic [PhaseCount-1:0] PhaseCoded = 5'b01011;
  // Bits per modulation mode, mode m at index m-1.
  localparam logic [8:0][3:0] ModeBits =
    {4'd12, 4'd10, 4'd9, 4'd8, 4'd6, 4'd4, 4'd3, 4'd2, 4'd1};

  class alloc_scoreboard;
    logic [oat_pkg::LoadW-1:0]  load_tbl  [Entries*Subcarriers];
    logic [oat_pkg::PowerW-1:0] power_tbl [Entries*Subcarriers];
    logic                       coded;
    logic [oat_pkg::SymW-1:0]   symbols;
    oat_pkg::out_item_t         pending_beats[$];
    int unsigned                mismatches;

    function new();
      foreach (load_tbl[i]) begin
        load_tbl[i]  = oat_pkg::LoadReset;
        power_tbl[i] = oat_pkg::PowerReset;
      end
      coded      = 1'b0;
      symbols    = oat_pkg::SymW'(1);
      mismatches = 0;
    endfunction

    function void set_register(logic [oat_pkg::CfgIdxW-1:0] idx,
                               logic [oat_pkg::CfgDataW-1:0] data);
      if (idx == oat_pkg::CfgCoding) begin
        coded = data[0];
      end else if (idx == oat_pkg::CfgSymbols) begin
        symbols = data[oat_pkg::SymW-1:0];
      end
    endfunction

    function logic [3:0] bits_of(logic [oat_pkg::LoadW-1:0] v);
      if (!coded) return v;
      if (v >= 1 && v <= 9) return ModeBits[v-1];
      return 4'd0;
    endfunction

    function void note_item(oat_pkg::in_item_t it);
      int unsigned                base;
      logic [oat_pkg::SumW-1:0]   load_sum;
      logic [oat_pkg::CountW-1:0] frame_bits;
      oat_pkg::out_item_t         beat;
      if (it.entry_id >= Entries) return;
      base = it.entry_id * Subcarriers;
      if (it.func == oat_pkg::FuncWrite) begin
        if (it.subcarrier < Subcarriers) begin
          load_tbl[base + it.subcarrier]  = it.bitloading;
          power_tbl[base + it.subcarrier] = it.power_bits;
        end
        return;
      end
      load_sum = '0;
      for (int unsigned sc = 0; sc < Subcarriers; sc++) begin
        load_sum = load_sum + bits_of(load_tbl[base + sc]);
        beat.sub_index = 6'(sc);
        beat.load_out  = load_tbl[base + sc];
        beat.power_out = power_tbl[base + sc];
        beat.last      = (sc == Subcarriers - 1);
        beat.bit_count = '0;
        if (beat.last) begin
          frame_bits = load_sum * symbols;
          if (coded) frame_bits = frame_bits >> 1;
          beat.bit_count = frame_bits;
        end
        pending_beats = {pending_beats, beat};
      end
    endfunction

    function void check_beat(oat_pkg::out_item_t got);
      oat_pkg::out_item_t want;
      logic               bad;
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected beat: sc=%0d load=%0d power=%h count=%0d last=%b",
                   got.sub_index, got.load_out, got.power_out, got.bit_count, got.last);
        return;
      end
      want = pending_beats.pop_front();
      bad = (got.sub_index !== want.sub_index) || (got.load_out !== want.load_out) ||
            (got.power_out !== want.power_out) || (got.bit_count !== want.bit_count) ||
            (got.last !== want.last);
      if (bad) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("beat mismatch: want sc=%0d load=%0d power=%h count=%0d last=%b,",
                   want.sub_index, want.load_out, want.power_out, want.bit_count,
                   want.last,
                   " got sc=%0d load=%0d power=%h count=%0d last=%b",
                   got.sub_index, got.load_out, got.power_out,
                   got.bit_count, got.last);
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  oat_pkg::in_item_t            in_data;
  logic                         out_valid;
  oat_pkg::out_item_t           out_data;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [oat_pkg::CfgIdxW-1:0]  cfg_index;
  logic [oat_pkg::CfgDataW-1:0] cfg_data;

  alloc_scoreboard     sb;
  longint unsigned     cycles = 0;
  int unsigned         burst_left = 0;

  always #5 clk = ~clk;

  ofdm_allocation_table_core #(
    .ENTRIES    (Entries),
    .SUBCARRIERS(Subcarriers)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_data);
      if (start && !busy) sb.note_item(in_data);
      if (out_valid) sb.check_beat(out_data);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic oat_pkg::in_item_t write_item(logic [7:0] id, logic [5:0] sc,
                                                   logic [3:0] load, logic [31:0] pwr);
    oat_pkg::in_item_t it;
    it.func       = oat_pkg::FuncWrite;
    it.entry_id   = id;
    it.subcarrier = sc;
    it.bitloading = load;
    it.power_bits = pwr;
    return it;
  endfunction

  // The unused fields of a read carry random values.
  function automatic oat_pkg::in_item_t read_item(logic [7:0] id);
    oat_pkg::in_item_t it;
    it.func       = oat_pkg::FuncRead;
    it.entry_id   = id;
    it.subcarrier = 6'($urandom_range(0, 63));
    it.bitloading = 4'($urandom_range(0, 15));
    it.power_bits = $urandom();
    return it;
  endfunction

  task automatic write_reg(input logic [oat_pkg::CfgIdxW-1:0] idx,
                           input logic [oat_pkg::CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input oat_pkg::in_item_t it);
    @(negedge clk);
    start   <= 1'b1;
    in_data <= it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
  endtask

  task automatic pause(input int unsigned gap);
    @(negedge clk);
    start <= 1'b0;
    repeat (gap - 1) @(negedge clk);
  endtask

  // Stops sending until every predicted beat has arrived and the block has settled.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic issue(input oat_pkg::in_item_t it);
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0:       drain();
        1, 2, 3: ;
        default: pause($urandom_range(1, 12));
      endcase
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    send_item(it);
  endtask

  initial begin
    oat_pkg::in_item_t it;
    int unsigned       sent;
    int unsigned       nwr;
    logic [7:0]        id;
    logic [9:0]        ds;

    sb        = new();
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_reg(oat_pkg::CfgCoding, 10'd0);
    write_reg(oat_pkg::CfgSymbols, 10'd1023);

    // Reset contents first, then the field extremes, then one entry holding every loading.
    send_item(read_item(8'd0));
    send_item(write_item(8'd255, 6'd63, 4'd15, 32'hFFFF_FFFF));
    send_item(write_item(8'd255, 6'd0, 4'd0, 32'h0000_0000));
    send_item(read_item(8'd255));
    for (int k = 0; k < 16; k++) begin
      send_item(write_item(8'd7, 6'(k), 4'(k),
                           (k % 2) ? 32'hAAAA_5555 ^ k : 32'h5555_AAAA ^ k));
    end
    send_item(read_item(8'd7));

    for (int p = 0; p < PhaseCount; p++) begin
      drain();
      case (p)
        0:       ds = 10'd1;
        1:       ds = 10'd1023;
        2:       ds = 10'd0;
        default: ds = 10'($urandom_range(2, 1022));
      endcase
      write_reg(oat_pkg::CfgCoding, oat_pkg::CfgDataW'(PhaseCoded[p]));
      write_reg(oat_pkg::CfgSymbols, ds);
      // Entry 7 was written with every loading value, so this covers each mode unless random writes hit it.
      issue(read_item(8'd7));

      sent = 0;
      while (sent < PhaseItems) begin
        if ($urandom_range(0, 99) < 85) begin
          id  = ($urandom_range(0, 99) < 80) ? HotIds[$urandom_range(0, 5)]
                                             : 8'($urandom_range(0, 255));
          nwr = $urandom_range(1, 12);
          repeat (nwr) begin
            issue(write_item(id, 6'($urandom_range(0, 63)), 4'($urandom_range(0, 15)),
                             $urandom()));
            sent++;
          end
          issue(read_item(id));
          sent++;
        end else begin
          it.func       = 1'($urandom_range(0, 1));
          it.entry_id   = 8'($urandom_range(0, 255));
          it.subcarrier = 6'($urandom_range(0, 63));
          it.bitloading = 4'($urandom_range(0, 15));
          it.power_bits = $urandom();
          issue(it);
          sent++;
        end
      end
    end

    drain();
    if (sb.mismatches == 0 && sb.pending_beats.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/oat_pkg.sv
hw/rtl/oat_mem.sv
hw/rtl/oat_ctrl.sv
hw/rtl/ofdm_allocation_table_core.sv
test/tb.sv
